FILE: rtl/mrsp_pkg.sv
// shared types, constants and a decode helper for the midi running status parser
// no dependencies

package mrsp_pkg;

   localparam logic [7:0] REALTIME_MIN = 8'hF8;
   localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
   localparam logic [7:0] STATUS_MASK  = 8'h80;
   localparam logic [7:0] KIND_MASK    = 8'hF0;
   localparam logic [7:0] KIND_PROGRAM = 8'hC0;
   localparam logic [7:0] KIND_CH_PRES = 8'hD0;
   localparam logic [7:0] NO_STATUS    = 8'h00;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DATA1 = 2'd1,
      PH_DATA2 = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] midi_byte;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [7:0] msg_data2;
      logic [7:0] msg_data1;
      logic [7:0] msg_status;
   } msg_type;

   // program change and channel pressure carry a single data byte
   function automatic logic one_data_byte(input logic [7:0] status);
      logic [7:0] kind;
      kind = status & KIND_MASK;
      return (kind == KIND_PROGRAM) || (kind == KIND_CH_PRES);
   endfunction

endpackage

FILE: rtl/midi_running_status_parser_core.sv
// midi running status parser, top level: byte stream in, channel messages out
// depends on mrsp_pkg, mrsp_in_stage, mrsp_decode, mrsp_out_stage
//
// usage
//   req_* carries one raw midi byte per transfer, req_tlast marks the packet end
//   rsp_* carries one complete channel message per transfer: status and two data
//   bytes, data2 zero for program change and channel pressure
//   throughput: one byte per cycle while the result register has room, set by the
//   combinational decode between the input register and the result register
//   a byte that completes a message shows up on rsp after it has passed the input
//   register, then the result register
//   bytes that finish no message produce no transfer
//   running status survives packet boundaries; an unfinished message is dropped
//   at packet end
//   reset (synchronous, active high) clears running status, the message phase
//   and the drop flag, and empties both registers
//   when the receiver stalls the result register holds; one more byte may sit
//   in the input register, then req_tready falls until a result is taken

module midi_running_status_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] midi_byte
   input  logic        req_tlast,   // packet_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] msg_status, [15:8] msg_data1, [23:16] msg_data2
);
   import mrsp_pkg::*;

   req_type req_item;
   req_type stage_item;
   logic    stage_valid;
   logic    stage_take;
   logic    out_space;
   logic    emit;
   msg_type dec_msg;
   msg_type out_msg;

   assign req_item.midi_byte  = req_tdata;
   assign req_item.packet_end = req_tlast;

   // a byte leaves the input register whenever the result register has room
   assign stage_take = stage_valid && out_space;

   mrsp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (req_item),
      .stage_valid (stage_valid),
      .stage_take  (stage_take),
      .stage_item  (stage_item)
   );

   mrsp_decode u_decode (
      .clock (clock),
      .reset (reset),
      .fire  (stage_take),
      .item  (stage_item),
      .emit  (emit),
      .msg   (dec_msg)
   );

   mrsp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_msg  (dec_msg),
      .space     (out_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_msg   (out_msg)
   );

   // message fields packed lowest first
   assign rsp_tdata = {out_msg.msg_data2, out_msg.msg_data1, out_msg.msg_status};

endmodule

FILE: rtl/mrsp_in_stage.sv
// input register stage: holds one accepted byte until the decoder consumes it
// depends on mrsp_pkg

module mrsp_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mrsp_pkg::req_type in_item,
   output logic             stage_valid,
   input  logic             stage_take,
   output mrsp_pkg::req_type stage_item
);
   import mrsp_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign in_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

FILE: rtl/mrsp_decode.sv
// parser state machine: running status, message phase, held data and drop flag
// depends on mrsp_pkg

module mrsp_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  mrsp_pkg::req_type item,
   output logic              emit,
   output mrsp_pkg::msg_type msg
);
   import mrsp_pkg::*;

   logic [7:0] run_status_ff, run_status_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] held_data1_ff, held_data1_in;
   logic       drop_rest_ff, drop_rest_in;
   logic [7:0] b;
   logic       single;

   assign b      = item.midi_byte;
   assign single = one_data_byte(run_status_ff);

   // next state
   always_comb begin
      run_status_in = run_status_ff;
      phase_in      = phase_ff;
      held_data1_in = held_data1_ff;
      drop_rest_in  = drop_rest_ff;
      if (fire) begin
         if (!drop_rest_ff) begin
            case (phase_ff)
               PH_DATA1: begin
                  if (single) begin
                     phase_in = PH_IDLE;
                  end else begin
                     held_data1_in = b;
                     phase_in      = PH_DATA2;
                  end
               end
               PH_DATA2: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
                  if (b >= REALTIME_MIN) begin
                     phase_in = PH_IDLE;
                  end else if ((b & STATUS_MASK) != 8'h00) begin
                     if (b >= SYSTEM_MIN) begin
                        run_status_in = NO_STATUS;
                     end else begin
                        run_status_in = b;
                        phase_in      = PH_DATA1;
                     end
                  end else if (run_status_ff == NO_STATUS) begin
                     drop_rest_in = 1'b1;
                  end else if (!single) begin
                     held_data1_in = b;
                     phase_in      = PH_DATA2;
                  end
               end
            endcase
         end
         if (item.packet_end) begin
            phase_in     = PH_IDLE;
            drop_rest_in = 1'b0;
         end
      end
   end

   // result decode
   always_comb begin
      emit           = 1'b0;
      msg.msg_status = run_status_ff;
      msg.msg_data1  = b;
      msg.msg_data2  = 8'h00;
      if (fire && !drop_rest_ff) begin
         case (phase_ff)
            PH_DATA1: begin
               emit = single;
            end
            PH_DATA2: begin
               emit          = 1'b1;
               msg.msg_data1 = held_data1_ff;
               msg.msg_data2 = b;
            end
            default: begin
               emit = ((b & STATUS_MASK) == 8'h00) && (run_status_ff != NO_STATUS)
                      && single;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_status_ff <= NO_STATUS;
         phase_ff      <= PH_IDLE;
         drop_rest_ff  <= 1'b0;
      end else begin
         run_status_ff <= run_status_in;
         phase_ff      <= phase_in;
         drop_rest_ff  <= drop_rest_in;
      end
      held_data1_ff <= held_data1_in;
   end

endmodule

FILE: rtl/mrsp_out_stage.sv
// result register: holds one completed message until the receiver takes it
// depends on mrsp_pkg

module mrsp_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mrsp_pkg::msg_type load_msg,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output mrsp_pkg::msg_type out_msg
);
   import mrsp_pkg::*;

   logic    valid_ff, valid_in;
   msg_type msg_ff, msg_in;

   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      msg_in   = msg_ff;
      if (space) begin
         valid_in = load;
         msg_in   = load_msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      msg_ff <= msg_in;
   end

   assign out_valid = valid_ff;
   assign out_msg   = msg_ff;

endmodule

FILE: sim/midi_running_status_parser_core_test.sv
// self-checking testbench for midi_running_status_parser_core: byte stream in, channel messages out
// depends on mrsp_pkg and the parser rtl; predicts each message in step with the accepted bytes

`timescale 1ns / 100ps

module midi_running_status_parser_core_test;

   import mrsp_pkg::*;

   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         DRAIN_CYCLES    = 8;     // rsp shows up after the input register and the result register
   localparam int         RANDOM_BYTES    = 400;   // per idle phase
   localparam logic [7:0] CHANNEL_MIN     = 8'h80;
   localparam logic [7:0] CHANNEL_MAX     = 8'hEF;
   localparam logic [7:0] DATA_MAX        = 8'h7F;

   // clock and reset
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   // request side, driven at the rising edge
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;     // [7:0] midi_byte
   logic        req_tlast  = 1'b0;   // packet_end

   // response side
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] msg_status, [15:8] msg_data1, [23:16] msg_data2

   // shadow parser state, advanced once per accepted byte
   logic [7:0]  running_status_q = NO_STATUS;
   phase_type   msg_phase_q      = PH_IDLE;
   logic [7:0]  held_data1_q     = '0;
   logic        drop_rest_q      = 1'b0;

   // messages predicted but not yet seen on rsp
   msg_type     pending_msgs[$];

   int          error_count   = 0;
   int          cycle_count   = 0;
   int          bytes_sent    = 0;

   // idle knobs, in percent per cycle
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;

   // long receiver hold-off: the test side bumps the request count, the receiver serves it
   int          hold_requests = 0;
   int          hold_served   = 0;
   int          hold_left     = 0;

   midi_running_status_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // program change and channel pressure carry one data byte, everything else two
   function automatic logic takes_one_data(input logic [7:0] status);
      logic [7:0] kind;
      kind = status & KIND_MASK;
      return (kind == KIND_PROGRAM) || (kind == KIND_CH_PRES);
   endfunction

   // advance the shadow parser by one byte; returns 1 when a message completes
   function automatic logic decode_midi_byte(input logic [7:0] b, input logic last,
                                             output msg_type msg);
      logic done;
      done = 1'b0;
      msg  = '0;
      if (!drop_rest_q) begin
         if (msg_phase_q == PH_DATA1) begin
            // inside a message any byte is data
            if (takes_one_data(running_status_q)) begin
               msg         = '{msg_data2: 8'h00, msg_data1: b, msg_status: running_status_q};
               done        = 1'b1;
               msg_phase_q = PH_IDLE;
            end else begin
               held_data1_q = b;
               msg_phase_q  = PH_DATA2;
            end
         end else if (msg_phase_q == PH_DATA2) begin
            msg         = '{msg_data2: b, msg_data1: held_data1_q, msg_status: running_status_q};
            done        = 1'b1;
            msg_phase_q = PH_IDLE;
         end else begin
            msg_phase_q = PH_IDLE;
            if (b >= REALTIME_MIN) begin
               // real-time byte between messages: skipped
            end else if ((b & STATUS_MASK) != 8'h00) begin
               if (b >= SYSTEM_MIN) begin
                  running_status_q = NO_STATUS;
               end else begin
                  running_status_q = b;
                  msg_phase_q      = PH_DATA1;
               end
            end else if (running_status_q == NO_STATUS) begin
               // stray data with no running status kills the rest of the packet
               drop_rest_q = 1'b1;
            end else if (takes_one_data(running_status_q)) begin
               msg  = '{msg_data2: 8'h00, msg_data1: b, msg_status: running_status_q};
               done = 1'b1;
            end else begin
               held_data1_q = b;
               msg_phase_q  = PH_DATA2;
            end
         end
      end
      // packet end discards an unfinished message but keeps running status
      if (last) begin
         msg_phase_q = PH_IDLE;
         drop_rest_q = 1'b0;
      end
      return done;
   endfunction

   // offer one byte, wait for its transfer, then predict
   task automatic send_byte(input logic [7:0] b, input logic last);
      msg_type msg;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (decode_midi_byte(b, last, msg)) pending_msgs.push_back(msg);
   endtask

   task automatic send_packet(input logic [7:0] pkt[$]);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   task automatic wait_until_drained();
      while (pending_msgs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_data_byte();
      // mostly clean data, now and then a byte with the top bit set
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(DATA_MAX));
   endfunction

   // one packet of random traffic, mostly well-formed messages
   task automatic send_random_packet();
      logic [7:0] pkt[$];
      logic [7:0] status;
      int         kind;
      int         n_msgs;
      int         n_data;
      kind   = $urandom_range(99);
      status = running_status_q;
      if (kind < 75) begin
         n_msgs = $urandom_range(1, 4);
         repeat (n_msgs) begin
            if ($urandom_range(9) == 0) pkt.push_back(REALTIME_MIN | 8'($urandom_range(7)));
            if (status == NO_STATUS || $urandom_range(2) == 0) begin
               status = 8'($urandom_range(CHANNEL_MIN, CHANNEL_MAX));
               pkt.push_back(status);
            end
            n_data = takes_one_data(status) ? 1 : 2;
            repeat (n_data) pkt.push_back(random_data_byte());
            // sometimes cut the message short
            if ($urandom_range(7) == 0) void'(pkt.pop_back());
         end
         if (pkt.size() == 0) pkt.push_back(random_data_byte());
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(255)));
      end else begin
         // system status clears running status, then data that has nowhere to go
         pkt.push_back(SYSTEM_MIN | 8'($urandom_range(7)));
         repeat ($urandom_range(0, 4)) pkt.push_back(random_data_byte());
      end
      send_packet(pkt);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // hand-picked bytes for every corner of the decode
   task automatic test_directed();
      set_idling(0, 0);
      send_packet('{8'h00, 8'h90});                 // data with no running status drops the packet
      send_packet('{8'hF8, 8'h80, 8'h00, 8'h7F, 8'h01});  // real-time skipped, lowest status,
                                                          // then an unfinished message at the end
      send_packet('{8'h12, 8'h34});                 // running status carried into the next packet
      set_idling(11, 11);
      send_packet('{8'hC3, 8'hFF, 8'h05, 8'hDF, 8'hF0}); // one-data kinds, status-looking data
      send_packet('{8'hEF, 8'hF8, 8'h90, 8'hF7, 8'h40, 8'hA0, 8'h41}); // highest channel status,
                                                                       // system clears, drop
      send_packet('{8'hB1});                        // status alone at packet end
      send_packet('{8'h55, 8'hFE});                 // running status survived the empty message
      req_tvalid <= 1'b0;
      wait_until_drained();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int n_bytes);
      int target;
      target = bytes_sent + n_bytes;
      set_idling(sender_pct, receiver_pct);
      while (bytes_sent < target) send_random_packet();
   endtask

   // receiver holds off for a long stretch while the sender keeps pushing messages
   task automatic test_backpressure();
      set_idling(0, 0);
      hold_requests++;
      repeat (30) send_packet('{8'($urandom_range(CHANNEL_MIN, CHANNEL_MAX)),
                                random_data_byte(), random_data_byte()});
      req_tvalid <= 1'b0;
      wait_until_drained();
   endtask

   // sender stops until every message is out, then resumes
   task automatic test_drain_pause();
      set_idling(11, 11);
      repeat (5) send_random_packet();
      req_tvalid <= 1'b0;
      wait_until_drained();
      @(posedge clock);
      repeat (5) send_random_packet();
   endtask

   // response side: random stalls plus the occasional long hold-off
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_OFF_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
         error_count++;
      end
   endtask

   // every rsp transfer is matched against the oldest predicted message
   always @(posedge clock) begin
      msg_type want;
      msg_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_msgs.size() == 0) begin
            $display("%0t: unexpected message, expected none, actual %06h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_msgs.pop_front();
            compare_field("msg_status", want.msg_status, got.msg_status);
            compare_field("msg_data1", want.msg_data1, got.msg_data1);
            compare_field("msg_data2", want.msg_data2, got.msg_data2);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(0, 0, RANDOM_BYTES);
      test_backpressure();
      test_random_traffic(84, 0, RANDOM_BYTES);
      test_drain_pause();
      test_random_traffic(0, 84, RANDOM_BYTES);
      test_random_traffic(11, 11, RANDOM_BYTES);

      // all bytes are in: let the last messages come out
      req_tvalid <= 1'b0;
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_msgs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
